### hdl/adsr_sine_voice_top_assert.svh
// Assertion macros for the ADSR sine voice.
// Needs signals named clk and rst in the including module.
`ifndef ADSR_SINE_VOICE_TOP_ASSERT_SVH
`define ADSR_SINE_VOICE_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define ADSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define ADSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/adsr_pkg.sv
// Shared types, constants and the quarter-wave sine table of the ADSR voice.
// No dependencies; every other file but the assertion header imports it.
package adsr_pkg;

  // Sizing
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SAMPLE_WIDTH     = 16;
  localparam int PHASE_W          = 32;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_W            = IDX_W - 2;
  localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;
  localparam int AMP_W            = SAMPLE_WIDTH - 1;
  localparam int FULL_SCALE       = (1 << (SAMPLE_WIDTH - 1)) - 1;

  // Envelope and register widths
  localparam int ENV_W      = 25;
  localparam int ENV_ONE    = 1 << 24;
  localparam int STEP_W     = 25;
  localparam int VOL_W      = 9;
  localparam int INC_W      = 31;
  localparam int STAGE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Multiplier sizing: volume*env, then that times |sine|
  localparam int PROD1_W   = VOL_W + ENV_W;
  localparam int MUL_B_W   = (AMP_W > VOL_W) ? AMP_W : VOL_W;
  localparam int PROD_W    = PROD1_W + MUL_B_W;
  localparam int RND_SHIFT = 32;
  localparam int MAG_W     = PROD_W + 1 - RND_SHIFT;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INCREMENT = 3'd5;

  // Register reset values
  localparam logic [STEP_W-1:0] RST_ATTACK_STEP     = 25'd381;
  localparam logic [STEP_W-1:0] RST_DECAY_STEP      = 25'd285;
  localparam logic [STEP_W-1:0] RST_RELEASE_STEP    = 25'd95;
  localparam logic [ENV_W-1:0]  RST_SUSTAIN_LEVEL   = 25'd4194304;
  localparam logic [VOL_W-1:0]  RST_VOLUME          = 9'd128;
  localparam logic [INC_W-1:0]  RST_PHASE_INCREMENT = 31'd25479016;

  // Output stage codes
  localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 3'd0;
  localparam logic [STAGE_W-1:0] STAGE_DECAY   = 3'd1;
  localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 3'd2;
  localparam logic [STAGE_W-1:0] STAGE_RELEASE = 3'd3;
  localparam logic [STAGE_W-1:0] STAGE_DONE    = 3'd4;

  typedef enum logic [4:0] {
    ENV_ATTACK  = 5'b00001,
    ENV_DECAY   = 5'b00010,
    ENV_SUSTAIN = 5'b00100,
    ENV_RELEASE = 5'b01000,
    ENV_DONE    = 5'b10000
  } env_state_t;

  typedef struct packed {
    logic [STEP_W-1:0] attack_step;
    logic [STEP_W-1:0] decay_step;
    logic [STEP_W-1:0] release_step;
    logic [ENV_W-1:0]  sustain_level;
    logic [VOL_W-1:0]  volume;
    logic [INC_W-1:0]  phase_increment;
  } cfg_regs_t;

  // Envelope update handed from the envelope unit to the sequencer
  typedef struct packed {
    logic [ENV_W-1:0] level;
    env_state_t       state;
    logic             active;
  } env_upd_t;

  function automatic logic [STAGE_W-1:0] stage_code(env_state_t s);
    logic [STAGE_W-1:0] c;
    unique case (s)
      ENV_ATTACK:  c = STAGE_ATTACK;
      ENV_DECAY:   c = STAGE_DECAY;
      ENV_SUSTAIN: c = STAGE_SUSTAIN;
      ENV_RELEASE: c = STAGE_RELEASE;
      default:     c = STAGE_DONE;
    endcase
    return c;
  endfunction

  // Sine polynomial, Q30, evaluated at elaboration only
  localparam longint Q30_ONE = longint'(1) << 30;
  localparam longint COEF1   = 1686629713;
  localparam longint COEF3   = -693598669;
  localparam longint COEF5   = 85569306;
  localparam longint COEF7   = -5026995;
  localparam longint COEF9   = 172272;

  function automatic logic [AMP_W-1:0] sine_amp(longint x);
    longint x2;
    longint t;
    longint s;
    x2 = x * x / Q30_ONE;
    t  = COEF9;
    t  = COEF7 + t * x2 / Q30_ONE;
    t  = COEF5 + t * x2 / Q30_ONE;
    t  = COEF3 + t * x2 / Q30_ONE;
    t  = COEF1 + t * x2 / Q30_ONE;
    s  = t * x / Q30_ONE;
    if (s < 0) s = 0;
    if (s > Q30_ONE) s = Q30_ONE;
    return AMP_W'((s * longint'(FULL_SCALE) + Q30_ONE / 2) / Q30_ONE);
  endfunction

  typedef logic [AMP_W-1:0] qtab_t [QTR_DEPTH];

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int i = 0; i < QTR_DEPTH; i++) begin
      tab[i] = sine_amp((longint'(i) << 30) / QTR_DEPTH);
    end
    return tab;
  endfunction

  // Quarter wave, entries 0..QTR_DEPTH-1; the peak point stands alone
  localparam qtab_t            SINE_QTR  = build_qtab();
  localparam logic [AMP_W-1:0] SINE_PEAK = sine_amp(Q30_ONE);

endpackage

### hdl/adsr_if.sv
// Valid/ready channels of the ADSR voice: note input, result output, register writes.
// Depends on adsr_pkg.
interface adsr_in_if import adsr_pkg::*; ();
  logic valid;
  logic ready;
  logic start_note;
  logic key_held;

  modport source (output valid, output start_note, output key_held, input ready);
  modport sink   (input valid, input start_note, input key_held, output ready);
endinterface

interface adsr_out_if import adsr_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [ENV_W-1:0]               envelope_level;
  logic [STAGE_W-1:0]             stage;
  logic                           note_done;

  modport source (output valid, output sample, output envelope_level, output stage,
                  output note_done, input ready);
  modport sink   (input valid, input sample, input envelope_level, input stage,
                  input note_done, output ready);
endinterface

interface adsr_cfg_if import adsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/adsr_env.sv
// Envelope unit: one add/subtract and clamp compare per sample tick.
// Depends on adsr_pkg.
module adsr_env import adsr_pkg::*; (
  input  logic [ENV_W-1:0] level,
  input  env_state_t       state,
  input  logic             start,
  input  logic             held,
  input  cfg_regs_t        regs,
  output env_upd_t         upd
);

  localparam int LVL_W = ENV_W + 2;
  localparam logic signed [LVL_W-1:0] FULL_S = LVL_W'(ENV_ONE);

  logic signed [LVL_W-1:0] lvl0;
  logic signed [LVL_W-1:0] step_s;
  logic signed [LVL_W-1:0] sum;
  logic signed [LVL_W-1:0] sus_s;
  logic signed [LVL_W-1:0] res;
  logic [STEP_W-1:0]       step;
  logic [ENV_W-1:0]        sus;
  env_state_t              st0;
  env_state_t              st1;

  // Start pulse applies before the update
  always_comb begin
    lvl0 = start ? '0 : signed'({2'b00, level});
    st0  = start ? ENV_ATTACK : state;
  end

  // Sustain clamped to full scale
  assign sus   = (regs.sustain_level > ENV_W'(ENV_ONE)) ? ENV_W'(ENV_ONE) : regs.sustain_level;
  assign sus_s = signed'({2'b00, sus});

  // Shared adder: rise in attack, fall in decay and release
  always_comb begin
    unique case (st0)
      ENV_DECAY:   step = regs.decay_step;
      ENV_RELEASE: step = regs.release_step;
      default:     step = regs.attack_step;
    endcase
    step_s = signed'({2'b00, step});
    if (st0 == ENV_DECAY || st0 == ENV_RELEASE) begin
      sum = lvl0 - step_s;
    end else begin
      sum = lvl0 + step_s;
    end
  end

  // Clamp and stage change
  always_comb begin
    res = lvl0;
    st1 = st0;
    unique case (st0)
      ENV_ATTACK: begin
        res = sum;
        if (sum >= FULL_S) begin
          res = FULL_S;
          st1 = ENV_DECAY;
        end
      end
      ENV_DECAY: begin
        res = sum;
        if (sum < sus_s) begin
          res = sus_s;
          st1 = ENV_SUSTAIN;
        end
      end
      ENV_SUSTAIN: begin
        res = sus_s;
        if (!held) st1 = ENV_RELEASE;
      end
      ENV_RELEASE: begin
        res = sum;
        if (sum < 0) begin
          res = '0;
          st1 = ENV_DONE;
        end
      end
      default: begin
        res = lvl0;
        st1 = st0;
      end
    endcase
  end

  assign upd.level  = res[ENV_W-1:0];
  assign upd.state  = st1;
  assign upd.active = (st0 != ENV_DONE);

endmodule

### hdl/adsr_mul.sv
// Shared multiplier with registered product, used twice per sample.
// Depends on adsr_pkg.
module adsr_mul import adsr_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [PROD1_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [PROD_W-1:0]  product
);

  // Product register, payload only
  always_ff @(posedge clk) begin
    if (en) product <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

### hdl/adsr_sine_voice_top.sv
// Top level of the ADSR sine voice: register file, sequencer, sine lookup, output register.
// Depends on adsr_pkg, adsr_if, adsr_env, adsr_mul and adsr_sine_voice_top_assert.svh.

// One note word is one audio sample tick. After a word is taken the block steps through
// SEQ_ENV, SEQ_MUL1, SEQ_MUL2 and SEQ_EMIT with it: envelope update with sine lookup and
// phase advance, volume times envelope in the shared multiplier, that product times the
// sine magnitude in the same multiplier, then rounding, saturation and the load of the
// result register. A new word is taken in the cycle the result register loads, so the
// block works on one word at a time, held back by the two passes through the one
// multiplier; a full result register stalls SEQ_EMIT until it drains. Register writes are
// taken at any time and must only be made while no word is in flight.
module adsr_sine_voice_top import adsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  adsr_in_if.sink           note,
  adsr_out_if.source        result,
  adsr_cfg_if.sink          cfg
);

  `include "adsr_sine_voice_top_assert.svh"

  typedef enum logic [4:0] {
    SEQ_IDLE = 5'b00001,
    SEQ_ENV  = 5'b00010,
    SEQ_MUL1 = 5'b00100,
    SEQ_MUL2 = 5'b01000,
    SEQ_EMIT = 5'b10000
  } seq_state_t;

  seq_state_t state;
  seq_state_t state_next;

  cfg_regs_t        regs;
  logic [ENV_W-1:0] env_level;
  env_state_t       env_state;
  logic [PHASE_W-1:0] osc_phase;
  logic             active;
  logic             start;
  logic             held;
  logic [AMP_W-1:0] mag;
  logic             neg;

  env_upd_t           upd;
  logic               accept;
  logic               can_load;
  logic               load;
  logic [PROD1_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  product;

  logic [IDX_W-1:0]   tab_idx;
  logic [QTR_W-1:0]   kq;
  logic [QTR_W-1:0]   kq_mir;
  logic [AMP_W-1:0]   amp;

  logic [PROD_W:0]           p_rnd;
  logic [MAG_W-1:0]          m_full;
  logic [AMP_W-1:0]          m_sat;
  logic [SAMPLE_WIDTH-1:0]   m_ext;
  logic [SAMPLE_WIDTH-1:0]   sample_val;

  // Register file
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.attack_step     <= RST_ATTACK_STEP;
      regs.decay_step      <= RST_DECAY_STEP;
      regs.release_step    <= RST_RELEASE_STEP;
      regs.sustain_level   <= RST_SUSTAIN_LEVEL;
      regs.volume          <= RST_VOLUME;
      regs.phase_increment <= RST_PHASE_INCREMENT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ATTACK_STEP:     regs.attack_step     <= cfg.data[STEP_W-1:0];
        REG_DECAY_STEP:      regs.decay_step      <= cfg.data[STEP_W-1:0];
        REG_RELEASE_STEP:    regs.release_step    <= cfg.data[STEP_W-1:0];
        REG_SUSTAIN_LEVEL:   regs.sustain_level   <= cfg.data[ENV_W-1:0];
        REG_VOLUME:          regs.volume          <= cfg.data[VOL_W-1:0];
        REG_PHASE_INCREMENT: regs.phase_increment <= cfg.data[INC_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign can_load   = !result.valid || result.ready;
  assign load       = (state == SEQ_EMIT) && can_load;
  assign note.ready = (state == SEQ_IDLE) || load;
  assign accept     = note.valid && note.ready;

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: if (note.valid) state_next = SEQ_ENV;
      SEQ_ENV:  state_next = SEQ_MUL1;
      SEQ_MUL1: state_next = SEQ_MUL2;
      SEQ_MUL2: state_next = SEQ_EMIT;
      SEQ_EMIT: if (can_load) state_next = note.valid ? SEQ_ENV : SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SEQ_IDLE;
    else     state <= state_next;
  end

  // Capture the note word
  always_ff @(posedge clk) begin
    if (accept) begin
      start <= note.start_note;
      held  <= note.key_held;
    end
  end

  // Envelope unit
  adsr_env u_env (
    .level (env_level),
    .state (env_state),
    .start (start),
    .held  (held),
    .regs  (regs),
    .upd   (upd)
  );

  // Sine lookup by quarter-wave symmetry
  always_comb begin
    tab_idx = osc_phase[PHASE_W-1 -: IDX_W];
    kq      = tab_idx[QTR_W-1:0];
    kq_mir  = ~kq + QTR_W'(1);
    if (tab_idx[IDX_W-2]) begin
      amp = (kq == '0) ? SINE_PEAK : SINE_QTR[kq_mir];
    end else begin
      amp = SINE_QTR[kq];
    end
  end

  // Voice state, phase and sine sample updated in the envelope cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      env_level <= '0;
      env_state <= ENV_DONE;
      osc_phase <= '0;
      active    <= 1'b0;
    end else if (state == SEQ_ENV) begin
      env_level <= upd.level;
      env_state <= upd.state;
      active    <= upd.active;
      if (upd.active) osc_phase <= osc_phase + PHASE_W'(regs.phase_increment);
    end
  end

  always_ff @(posedge clk) begin
    if (state == SEQ_ENV) begin
      mag <= amp;
      neg <= tab_idx[IDX_W-1];
    end
  end

  // Shared multiplier operands
  always_comb begin
    if (state == SEQ_MUL2) begin
      mul_a = product[PROD1_W-1:0];
      mul_b = MUL_B_W'(mag);
    end else begin
      mul_a = PROD1_W'(env_level);
      mul_b = MUL_B_W'(regs.volume);
    end
  end

  adsr_mul u_mul (
    .clk     (clk),
    .en      ((state == SEQ_MUL1) || (state == SEQ_MUL2)),
    .a       (mul_a),
    .b       (mul_b),
    .product (product)
  );

  // Round, saturate and sign
  always_comb begin
    p_rnd  = {1'b0, product} + ((PROD_W + 1)'(1) << (RND_SHIFT - 1));
    m_full = p_rnd[PROD_W:RND_SHIFT];
    m_sat  = (m_full > MAG_W'(FULL_SCALE)) ? AMP_W'(FULL_SCALE) : m_full[AMP_W-1:0];
    m_ext  = {1'b0, m_sat};
    if (!active)  sample_val = '0;
    else if (neg) sample_val = -m_ext;
    else          sample_val = m_ext;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.sample         <= signed'(sample_val);
      result.envelope_level <= env_level;
      result.stage          <= stage_code(env_state);
      result.note_done      <= (env_state == ENV_DONE);
    end
  end

  // Checks
  `ADSR_ASSERT_IMPL(a_level_bound, 1'b1, env_level <= ENV_W'(ENV_ONE), "envelope above full scale")
  `ADSR_ASSERT_IMPL(a_done_flag, result.valid, result.note_done == (result.stage == STAGE_DONE), "done flag disagrees with stage")
  `ADSR_ASSERT_IMPL(a_done_silent, result.valid && result.note_done, result.sample == '0, "done note not silent")
  `ADSR_ASSERT_NEXT(a_phase_hold, state != SEQ_ENV, osc_phase == $past(osc_phase), "phase moved outside envelope cycle")

endmodule

### tb/sv/adsr_voice_checker.sv
`timescale 1ns / 100ps
// Result checker for the ADSR sine voice: tracks register writes, predicts each
// result word from the accepted note words and compares field by field.
// Depends on adsr_pkg and the channel interfaces in adsr_if.
module adsr_voice_checker import adsr_pkg::*; (
  input  logic clk,
  input  logic rst,
  adsr_in_if   note,
  adsr_out_if  result,
  adsr_cfg_if  cfg,
  output int   mismatch_cnt,
  output int   due_cnt
);

  // Sine polynomial in Q30
  localparam longint Q30 = longint'(1) << 30;
  localparam longint P1  = 1686629713;
  localparam longint P3  = -693598669;
  localparam longint P5  = 85569306;
  localparam longint P7  = -5026995;
  localparam longint P9  = 172272;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [ENV_W-1:0]               level;
    logic [STAGE_W-1:0]             stage;
    logic                           done;
  } voice_word_t;

  // Register copies
  logic [STEP_W-1:0] atk_step = RST_ATTACK_STEP;
  logic [STEP_W-1:0] dec_step = RST_DECAY_STEP;
  logic [STEP_W-1:0] rel_step = RST_RELEASE_STEP;
  logic [ENV_W-1:0]  sus_lvl  = RST_SUSTAIN_LEVEL;
  logic [VOL_W-1:0]  vol      = RST_VOLUME;
  logic [INC_W-1:0]  ph_inc   = RST_PHASE_INCREMENT;

  // Voice state
  logic [ENV_W-1:0]   env_q   = '0;
  logic [STAGE_W-1:0] stage_q = STAGE_DONE;
  logic [31:0]        phase_q = '0;

  voice_word_t due_words[$];
  voice_word_t want;
  int          fails = 0;

  // Signed table value at the current phase, full scale 2^(SAMPLE_WIDTH-1)-1
  function automatic longint sine_value(input logic [31:0] ph);
    longint idx;
    longint quart;
    longint x;
    longint x2;
    longint t;
    longint s;
    longint amp;
    idx   = (longint'(ph) * SINE_TABLE_DEPTH) >> 32;
    quart = ((4 * idx) / SINE_TABLE_DEPTH) & 3;
    x     = (((4 * idx) % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
    if ((quart & 1) != 0) x = Q30 - x;
    x2 = x * x / Q30;
    t  = P9;
    t  = P7 + t * x2 / Q30;
    t  = P5 + t * x2 / Q30;
    t  = P3 + t * x2 / Q30;
    t  = P1 + t * x2 / Q30;
    s  = t * x / Q30;
    if (s < 0) s = 0;
    if (s > Q30) s = Q30;
    amp = (s * longint'(FULL_SCALE) + Q30 / 2) / Q30;
    return (quart >= 2) ? -amp : amp;
  endfunction

  // One sample tick: start pulse, envelope step, sample, phase advance
  function automatic voice_word_t advance_voice(input logic start, input logic held);
    voice_word_t w;
    longint      sus;
    longint      lv;
    longint      sn;
    logic [63:0] mag;
    logic [63:0] prod;
    sus = (sus_lvl > ENV_ONE) ? longint'(ENV_ONE) : longint'(sus_lvl);
    w.sample = '0;
    if (start) begin
      env_q   = '0;
      stage_q = STAGE_ATTACK;
    end
    if (stage_q < STAGE_DONE) begin
      lv = longint'(env_q);
      case (stage_q)
        STAGE_ATTACK: begin
          lv = lv + longint'(atk_step);
          if (lv >= ENV_ONE) begin
            lv      = longint'(ENV_ONE);
            stage_q = STAGE_DECAY;
          end
        end
        STAGE_DECAY: begin
          // leaves decay only once strictly under the sustain level
          lv = lv - longint'(dec_step);
          if (lv < sus) begin
            lv      = sus;
            stage_q = STAGE_SUSTAIN;
          end
        end
        STAGE_SUSTAIN: begin
          lv = sus;
          if (!held) stage_q = STAGE_RELEASE;
        end
        default: begin
          // an exact zero stays in release
          lv = lv - longint'(rel_step);
          if (lv < 0) begin
            lv      = 0;
            stage_q = STAGE_DONE;
          end
        end
      endcase
      env_q = ENV_W'(lv);
      sn    = sine_value(phase_q);
      mag   = (sn < 0) ? 64'(-sn) : 64'(sn);
      prod  = 64'(vol) * 64'(env_q) * mag;
      prod  = (prod + 64'h8000_0000) >> 32;
      if (prod > 64'(FULL_SCALE)) prod = 64'(FULL_SCALE);
      w.sample = (sn < 0) ? -SAMPLE_WIDTH'(prod) : SAMPLE_WIDTH'(prod);
      phase_q  = phase_q + 32'(ph_inc);
    end
    w.level = env_q;
    w.stage = stage_q;
    w.done  = (stage_q >= STAGE_DONE);
    return w;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      atk_step = RST_ATTACK_STEP;
      dec_step = RST_DECAY_STEP;
      rel_step = RST_RELEASE_STEP;
      sus_lvl  = RST_SUSTAIN_LEVEL;
      vol      = RST_VOLUME;
      ph_inc   = RST_PHASE_INCREMENT;
      env_q    = '0;
      stage_q  = STAGE_DONE;
      phase_q  = '0;
      due_words.delete();
    end else begin
      // register writes, masked to their widths
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ATTACK_STEP:     atk_step = cfg.data[STEP_W-1:0];
          REG_DECAY_STEP:      dec_step = cfg.data[STEP_W-1:0];
          REG_RELEASE_STEP:    rel_step = cfg.data[STEP_W-1:0];
          REG_SUSTAIN_LEVEL:   sus_lvl  = cfg.data[ENV_W-1:0];
          REG_VOLUME:          vol      = cfg.data[VOL_W-1:0];
          REG_PHASE_INCREMENT: ph_inc   = cfg.data[INC_W-1:0];
          default: ;
        endcase
      end

      // result words against the oldest prediction
      if (result.valid && result.ready) begin
        if (due_words.size() == 0) begin
          $error("result word with no prediction waiting");
          fails++;
        end else begin
          want = due_words.pop_front();
          if (result.sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, result.sample);
            fails++;
          end
          if (result.envelope_level !== want.level) begin
            $error("envelope_level: expected %0d, got %0d", want.level,
                   result.envelope_level);
            fails++;
          end
          if (result.stage !== want.stage) begin
            $error("stage: expected %0d, got %0d", want.stage, result.stage);
            fails++;
          end
          if (result.note_done !== want.done) begin
            $error("note_done: expected %0b, got %0b", want.done, result.note_done);
            fails++;
          end
        end
      end

      // queue the prediction at the tail
      if (note.valid && note.ready)
        due_words.insert(due_words.size(), advance_voice(note.start_note, note.key_held));
    end
    mismatch_cnt <= fails;
    due_cnt      <= due_words.size();
  end

endmodule

### tb/sv/adsr_sine_voice_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for adsr_sine_voice_top: clock, reset, note and register stimulus,
// result-side backpressure and the verdict. Depends on adsr_pkg, adsr_if, adsr_voice_checker.
module adsr_sine_voice_top_tb;
  import adsr_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int RAND_ROUNDS = 8;
  localparam int ROUND_WORDS = 120;
  localparam int STEP_MAX    = (1 << STEP_W) - 1;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE = 3'd6;
  localparam logic [CFG_DATA_W-1:0] ALL_ONES  = '1;

  logic clk;
  logic rst;
  logic calm;
  int   hold_ask;
  int   mismatch_cnt;
  int   due_cnt;
  int   note_cnt = 0;

  adsr_in_if  note_ch ();
  adsr_out_if result_ch ();
  adsr_cfg_if cfg_ch ();

  adsr_sine_voice_top dut (
    .clk    (clk),
    .rst    (rst),
    .note   (note_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  adsr_voice_checker voice_chk (
    .clk          (clk),
    .rst          (rst),
    .note         (note_ch),
    .result       (result_ch),
    .cfg          (cfg_ch),
    .mismatch_cnt (mismatch_cnt),
    .due_cnt      (due_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < RUN_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls, calm stretches, and long hold-offs on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (calm) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= 12);
      end
    end
  end

  // One note word, with an occasional random gap ahead of it
  task automatic send_note(input logic start, input logic held);
    if (!calm && $urandom_range(99) < 12) begin
      note_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    note_ch.valid      <= 1'b1;
    note_ch.start_note <= start;
    note_ch.key_held   <= held;
    do @(posedge clk); while (!note_ch.ready);
    note_cnt++;
  endtask

  // Key press, held ticks, then released ticks
  task automatic play_note(input int held_ticks, input int free_ticks);
    send_note(1'b1, 1'b1);
    repeat (held_ticks) send_note(1'b0, 1'b1);
    repeat (free_ticks) send_note(1'b0, 1'b0);
  endtask

  // Stop offering and wait until every predicted word has come back
  task automatic settle();
    note_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] atk, input logic [CFG_DATA_W-1:0] dec,
                           input logic [CFG_DATA_W-1:0] rel, input logic [CFG_DATA_W-1:0] sus,
                           input logic [CFG_DATA_W-1:0] vol, input logic [CFG_DATA_W-1:0] inc);
    write_reg(REG_ATTACK_STEP, atk);
    write_reg(REG_DECAY_STEP, dec);
    write_reg(REG_RELEASE_STEP, rel);
    write_reg(REG_SUSTAIN_LEVEL, sus);
    write_reg(REG_VOLUME, vol);
    write_reg(REG_PHASE_INCREMENT, inc);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly steps that take 1..40 ticks per stage, plus zero, max and raw bits
  function automatic logic [CFG_DATA_W-1:0] pick_step();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return CFG_DATA_W'(STEP_MAX);
    if (r < 15) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'(ENV_ONE / $urandom_range(1, 40) + $urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_sustain();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return CFG_DATA_W'(ENV_ONE);
    if (r < 30) return CFG_DATA_W'($urandom_range(ENV_ONE + 1, STEP_MAX));
    if (r < 35) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, ENV_ONE));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_volume();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return CFG_DATA_W'(256);
    if (r < 30) return CFG_DATA_W'((1 << VOL_W) - 1);
    if (r < 35) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, (1 << VOL_W) - 1));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_increment();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return ALL_ONES;
    return CFG_DATA_W'($urandom);
  endfunction

  // Stimulus and verdict
  initial begin
    int first;
    rst                <= 1'b1;
    calm               <= 1'b0;
    hold_ask           <= 0;
    note_ch.valid      <= 1'b0;
    note_ch.start_note <= 1'b0;
    note_ch.key_held   <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_ATTACK_STEP;
    cfg_ch.data        <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Full pass through every stage; decay lands exactly on sustain before
    // going under it, and release hits exactly zero before it ends
    load_regs(CFG_DATA_W'(1 << 22), CFG_DATA_W'(1 << 21), CFG_DATA_W'(1 << 21),
              CFG_DATA_W'(1 << 23), CFG_DATA_W'(256), ALL_ONES);
    send_note(1'b0, 1'b0);
    play_note(10, 6);
    send_note(1'b0, 1'b0);
    send_note(1'b1, 1'b0);
    settle();

    // Extreme values: one-tick attack, sustain above full scale, gain past 1.0,
    // frozen phase, and a write to an unused index
    write_reg(REG_SPARE, ALL_ONES);
    load_regs(ALL_ONES, CFG_DATA_W'(1), CFG_DATA_W'(STEP_MAX), ALL_ONES,
              CFG_DATA_W'((1 << VOL_W) - 1), '0);
    play_note(1, 3);
    settle();

    // All zero but the phase increment: attack never leaves zero, output silent
    load_regs('0, '0, '0, '0, '0, CFG_DATA_W'(1 << 22));
    play_note(1, 0);

    // Random rounds: mostly whole notes, some loose words
    for (int r = 0; r < RAND_ROUNDS; r++) begin
      settle();
      load_regs(pick_step(), pick_step(), pick_step(), pick_sustain(), pick_volume(),
                pick_increment());
      if (r == 2) calm <= 1'b1;
      if (r == 3) calm <= 1'b0;
      if (r == 4 || r == 6) hold_ask <= hold_ask + 1;
      first = note_cnt;
      while (note_cnt - first < ROUND_WORDS) begin
        if ($urandom_range(99) < 80)
          play_note($urandom_range(0, 48), $urandom_range(0, 48));
        else
          repeat ($urandom_range(1, 6))
            send_note($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
      end
    end
    settle();

    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
